### sv/qswc_pkg.sv
// qswc_pkg: shared constants, types and helper functions for the QPSK sync word correlator.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package qswc_pkg;

  localparam int FRAME_MAX     = 16384;
  localparam int WINDOW_LEN    = 64;
  localparam int PATTERN_COUNT = 8;

  localparam int SAMPLE_W  = 8;
  localparam int SCORE_W   = 7;
  localparam int POS_W     = 14;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = $clog2(FRAME_MAX + WINDOW_LEN + 1);
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SAMPLE_W-1:0]   HARD_ONE_MAX     = 8'd127;
  localparam logic [SCORE_W-1:0]    DETECT_LIMIT_RST = 7'd55;
  localparam logic [WINDOW_LEN-1:0] MASK_EVEN        = {8{8'h55}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_WORD    = 2'd0,
    CFG_DETECT_LIMIT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    ITEM_SCORE = 1'b0,
    ITEM_LAST  = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e              kind;
    logic [POS_W-1:0]        start;
    logic [WINDOW_LEN-1:0]   window;
  } q_entry_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   pattern_index;
    logic [POS_W-1:0]   best_position;
    logic [SCORE_W-1:0] peak_score;
    logic               early_hit;
  } result_t;

  function automatic logic [WINDOW_LEN-1:0] phase_turn(input logic [WINDOW_LEN-1:0] x);
    return (((x & MASK_EVEN) ^ MASK_EVEN) << 1) | ((x & ~MASK_EVEN) >> 1);
  endfunction

  function automatic logic [WINDOW_LEN-1:0] iq_swap(input logic [WINDOW_LEN-1:0] x);
    return ((x & MASK_EVEN) << 1) | ((x & ~MASK_EVEN) >> 1);
  endfunction

  // n[2] picks the IQ-swapped word, n[1:0] the QPSK phase
  function automatic logic [WINDOW_LEN-1:0] pattern_of(input logic [WINDOW_LEN-1:0] sw,
                                                       input logic [IDX_W-1:0]      n);
    logic [WINDOW_LEN-1:0] r;
    r = n[2] ? iq_swap(sw) : sw;
    if (n[0]) begin
      r = phase_turn(r);
    end
    if (n[1]) begin
      r = ~r;
    end
    return r;
  endfunction

  function automatic logic [SCORE_W-1:0] ones_count(input logic [WINDOW_LEN-1:0] x);
    logic [SCORE_W-1:0] c;
    c = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      c = c + SCORE_W'(x[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/qswc_front.sv
// qswc_front: hard decision, sample window and window classification.
// Depends on qswc_pkg; feeds qswc_queue.
`default_nettype none

module qswc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [qswc_pkg::SAMPLE_W-1:0] soft_sample_i,
  input  wire logic                          frame_end_i,
  input  wire logic                          q_full_i,
  output      logic                          in_stall_o,
  output      logic                          push_o,
  output      qswc_pkg::q_entry_t            entry_o
);
  import qswc_pkg::*;

  logic [WINDOW_LEN-1:0] window_q, window_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      start_full;
  logic                  accept, hard_bit, in_range;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hard_bit   = (soft_sample_i <= HARD_ONE_MAX);
  assign window_d   = {window_q[WINDOW_LEN-2:0], hard_bit};
  assign start_full = count_q - CNT_W'(WINDOW_LEN - 1);
  // window complete and its start below the frame limit
  assign in_range   = (count_q >= CNT_W'(WINDOW_LEN - 1)) &&
                      (count_q <  CNT_W'(FRAME_MAX + WINDOW_LEN - 1));

  always_comb begin
    count_d = count_q;
    if (count_q < CNT_W'(FRAME_MAX + WINDOW_LEN)) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  assign push_o        = accept && (frame_end_i || in_range);
  assign entry_o.kind   = frame_end_i ? ITEM_LAST : ITEM_SCORE;
  assign entry_o.start  = start_full[POS_W-1:0];
  assign entry_o.window = window_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
    end else if (accept) begin
      if (frame_end_i) begin
        window_q <= '0;
        count_q  <= '0;
      end else begin
        window_q <= window_d;
        count_q  <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

### sv/qswc_queue.sv
// qswc_queue: short FIFO of classified windows between front and back.
// Depends on qswc_pkg.
`default_nettype none

module qswc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire qswc_pkg::q_entry_t entry_i,
  output      logic               full_o,
  output      logic               valid_o,
  output      qswc_pkg::q_entry_t entry_o,
  input  wire logic               pop_i
);
  import qswc_pkg::*;

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
        2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/qswc_back.sv
// qswc_back: pattern scoring, per-pattern best tracking and result register.
// Depends on qswc_pkg; drains qswc_queue.
`default_nettype none

module qswc_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire qswc_pkg::q_entry_t              q_entry_i,
  output      logic                            q_pop_o,
  input  wire logic [qswc_pkg::WINDOW_LEN-1:0] sync_word_i,
  input  wire logic [qswc_pkg::SCORE_W-1:0]    detect_limit_i,
  input  wire logic                            out_stall_i,
  output      logic                            out_valid_o,
  output      qswc_pkg::result_t               result_o
);
  import qswc_pkg::*;

  // score stage
  logic               s1_valid_q;
  item_kind_e         s1_kind_q;
  logic [POS_W-1:0]   s1_start_q;
  logic [SCORE_W-1:0] s1_score_q [PATTERN_COUNT];
  logic [SCORE_W-1:0] score_d    [PATTERN_COUNT];

  // frame state
  logic               done_q;
  logic [SCORE_W-1:0] best_score_q [PATTERN_COUNT];
  logic [POS_W-1:0]   best_start_q [PATTERN_COUNT];

  logic               out_valid_q;
  result_t            out_q, res_d;

  logic                     s2_fire, produce, hit, any;
  logic [IDX_W-1:0]         hit_idx, pick;
  logic [SCORE_W-1:0]       top;
  logic [PATTERN_COUNT-1:0] upd;

  assign s2_fire = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o = q_valid_i && (!s1_valid_q || s2_fire);

  always_comb begin
    for (int n = 0; n < PATTERN_COUNT; n++) begin
      score_d[n] = ones_count(~(q_entry_i.window ^ pattern_of(sync_word_i, IDX_W'(n))));
    end
  end

  // new bests in index order, stopping at the first one over the limit
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    upd     = '0;
    for (int n = 0; n < PATTERN_COUNT; n++) begin
      if (!hit && (s1_score_q[n] > best_score_q[n])) begin
        upd[n] = 1'b1;
        if (s1_score_q[n] > detect_limit_i) begin
          hit     = 1'b1;
          hit_idx = IDX_W'(n);
        end
      end
    end
  end

  // end-of-frame pick, lowest index wins a tie
  always_comb begin
    top  = '0;
    pick = '0;
    any  = 1'b0;
    for (int n = 0; n < PATTERN_COUNT; n++) begin
      if (best_score_q[n] > top) begin
        top  = best_score_q[n];
        pick = IDX_W'(n);
        any  = 1'b1;
      end
    end
  end

  always_comb begin
    if (s1_kind_q == ITEM_LAST) begin
      res_d.found         = any;
      res_d.pattern_index = pick;
      res_d.best_position = any ? best_start_q[pick] : '0;
      res_d.peak_score    = top;
      res_d.early_hit     = 1'b0;
    end else begin
      res_d.found         = 1'b1;
      res_d.pattern_index = hit_idx;
      res_d.best_position = s1_start_q;
      res_d.peak_score    = s1_score_q[hit_idx];
      res_d.early_hit     = 1'b1;
    end
  end

  assign produce = !done_q && ((s1_kind_q == ITEM_LAST) || hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      s1_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_kind_q  <= q_entry_i.kind;
      s1_start_q <= q_entry_i.start;
      s1_score_q <= score_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q       <= 1'b0;
      best_score_q <= '{default: '0};
    end else if (s2_fire) begin
      if (s1_kind_q == ITEM_LAST) begin
        done_q       <= 1'b0;
        best_score_q <= '{default: '0};
      end else if (!done_q) begin
        for (int n = 0; n < PATTERN_COUNT; n++) begin
          if (upd[n]) begin
            best_score_q[n] <= s1_score_q[n];
          end
        end
        if (hit) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // a start is only read once its score has risen above zero this frame
  always_ff @(posedge clk_i) begin
    if (s2_fire && (s1_kind_q == ITEM_SCORE) && !done_q) begin
      for (int n = 0; n < PATTERN_COUNT; n++) begin
        if (upd[n]) begin
          best_start_q[n] <= s1_start_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire && produce) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && produce) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

### sv/qpsk_sync_word_correlator.sv
// qpsk_sync_word_correlator: top level, configuration registers and front/queue/back wiring.
// Depends on qswc_pkg, qswc_front, qswc_queue and qswc_back.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  in       | sink      | in_valid_i / in_stall_o | soft_sample_i, frame_end_i
//  out      | source    | out_valid_o / out_stall_i | found_o, pattern_index_o,
//           |           |                        | best_position_o, peak_score_o, early_hit_o
//  cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One sample per cycle sustained while the queue has room. A result passes through the queue
// write, then the scoring stage, then the result register before it is valid on the out port.
// The scoring stage registers all eight 64-bit match counts together; best tracking follows.
// The four-entry queue absorbs a stalled result; in_stall_o rises only when it is full.
// Reset clears the window, sample count, scores and pipeline; sync_word resets to zero and
// detect_limit to 55. cfg_ready_o is always high.
`default_nettype none

module qpsk_sync_word_correlator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // sample input
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [qswc_pkg::SAMPLE_W-1:0]    soft_sample_i,
  input  wire logic                             frame_end_i,
  // result output
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             found_o,
  output      logic [qswc_pkg::IDX_W-1:0]       pattern_index_o,
  output      logic [qswc_pkg::POS_W-1:0]       best_position_o,
  output      logic [qswc_pkg::SCORE_W-1:0]     peak_score_o,
  output      logic                             early_hit_o,
  // register writes
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [qswc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [qswc_pkg::WINDOW_LEN-1:0]  cfg_data_i
);
  import qswc_pkg::*;

  logic [WINDOW_LEN-1:0] sync_word_q;
  logic [SCORE_W-1:0]    detect_limit_q;

  logic     push, q_full, q_valid, q_pop;
  q_entry_t push_entry, head_entry;
  result_t  result;

  // the user must change registers only between frames; the block has no write guard and does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q    <= '0;
      detect_limit_q <= DETECT_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SYNC_WORD:    sync_word_q    <= cfg_data_i;
        CFG_DETECT_LIMIT: detect_limit_q <= cfg_data_i[SCORE_W-1:0];
        default:          ; // unknown index: beat dropped
      endcase
    end
  end

  // front: hard decision and window, only complete in-range windows and frame ends go on
  qswc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .soft_sample_i (soft_sample_i),
    .frame_end_i   (frame_end_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  qswc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (q_pop)
  );

  // back: scoring, best tracking, early hit and end-of-frame pick
  qswc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (head_entry),
    .q_pop_o        (q_pop),
    .sync_word_i    (sync_word_q),
    .detect_limit_i (detect_limit_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .result_o       (result)
  );

  assign found_o         = result.found;
  assign pattern_index_o = result.pattern_index;
  assign best_position_o = result.best_position;
  assign peak_score_o    = result.peak_score;
  assign early_hit_o     = result.early_hit;

endmodule

`default_nettype wire

### sv/qswc_checker.sv
// qswc_checker: port-level assertions for the correlator, bound to the top level.
// Depends on qswc_pkg and qpsk_sync_word_correlator.
`default_nettype none

module qswc_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic                           found_o,
  input wire logic [qswc_pkg::IDX_W-1:0]     pattern_index_o,
  input wire logic [qswc_pkg::POS_W-1:0]     best_position_o,
  input wire logic [qswc_pkg::SCORE_W-1:0]   peak_score_o,
  input wire logic                           early_hit_o
);
  import qswc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(pattern_index_o) && $stable(best_position_o) && $stable(peak_score_o) &&
      $stable(early_hit_o))
    else $error("stalled result changed");

  // an empty frame reports all-zero fields
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> pattern_index_o == '0 && best_position_o == '0 &&
      peak_score_o == '0 && !early_hit_o)
    else $error("not-found result with nonzero fields");

  // a found pattern always has a nonzero score within the window length
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> peak_score_o != '0 &&
      peak_score_o <= SCORE_W'(WINDOW_LEN))
    else $error("peak score out of range");

  // an early hit needs a score that beat some limit, so at least one match
  a_early_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && early_hit_o |-> found_o && peak_score_o != '0)
    else $error("early hit without a found pattern");

endmodule

bind qpsk_sync_word_correlator qswc_checker u_qswc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .found_o         (found_o),
  .pattern_index_o (pattern_index_o),
  .best_position_o (best_position_o),
  .peak_score_o    (peak_score_o),
  .early_hit_o     (early_hit_o)
);

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking testbench for qpsk_sync_word_correlator.
// Holds its own model of the correlator, drives samples and register writes with random
// idling, and checks every result beat. Depends on qswc_pkg and the block's RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qswc_pkg::*;

  // Run limits.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 6;     // lets the queue, scoring stage and result register drain
  localparam int RANDOM_ITEMS  = 400;

  // Register indexes the block does not decode; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [WINDOW_LEN-1:0] WORD_EVEN = {8{8'h55}};
  localparam logic [WINDOW_LEN-1:0] WORD_ODD  = {8{8'hAA}};

  // ---------------------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic [SAMPLE_W-1:0]   soft_sample_i = '0;
  logic                  frame_end_i   = 1'b0;
  logic                  out_stall_i   = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_SYNC_WORD;
  logic [WINDOW_LEN-1:0] cfg_data_i    = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  found_o;
  logic [IDX_W-1:0]      pattern_index_o;
  logic [POS_W-1:0]      best_position_o;
  logic [SCORE_W-1:0]    peak_score_o;
  logic                  early_hit_o;
  logic                  cfg_ready_o;

  always #6 clk_i = ~clk_i;

  qpsk_sync_word_correlator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .soft_sample_i  (soft_sample_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .pattern_index_o(pattern_index_o),
    .best_position_o(best_position_o),
    .peak_score_o   (peak_score_o),
    .early_hit_o    (early_hit_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------------------
  // Correlator model state: configuration, derived pattern bank and per-frame tracking
  // ---------------------------------------------------------------------------------------
  logic [WINDOW_LEN-1:0] cur_sync;
  logic [SCORE_W-1:0]    cur_limit;
  logic [WINDOW_LEN-1:0] pat_bank [PATTERN_COUNT];
  logic [WINDOW_LEN-1:0] win_bits;        // newest hard bit in bit 0
  int unsigned           top_score [PATTERN_COUNT];
  int unsigned           top_start [PATTERN_COUNT];
  int unsigned           sample_idx;      // saturating count within the frame
  bit                    frame_locked;    // set by an early hit until frame end

  result_t     pending_results [$];       // results owed by the block, oldest first
  int unsigned fed_samples = 0;           // beats that reached the correlator proper
  int unsigned results_due = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles_run  = 0;
  bit          idle_en     = 1'b1;        // random gaps on both sides
  int          stall_left  = 0;

  // QPSK quarter turn on each I/Q bit pair: odd bit takes the inverted even bit,
  // even bit takes the odd bit.
  function automatic logic [WINDOW_LEN-1:0] rotate_quadrant(input logic [WINDOW_LEN-1:0] w);
    logic [WINDOW_LEN-1:0] r;
    for (int k = 0; k < WINDOW_LEN; k += 2) begin
      r[k+1] = ~w[k];
      r[k]   = w[k+1];
    end
    return r;
  endfunction

  // I/Q exchange within each bit pair
  function automatic logic [WINDOW_LEN-1:0] swap_rails(input logic [WINDOW_LEN-1:0] w);
    logic [WINDOW_LEN-1:0] r;
    for (int k = 0; k < WINDOW_LEN; k += 2) begin
      r[k+1] = w[k];
      r[k]   = w[k+1];
    end
    return r;
  endfunction

  // Bank entries 0-3 are the word's four phases, 4-7 the same for the swapped word.
  // Odd phases take the quarter turn, phases 2 and 3 are inverted.
  task automatic load_sync_word(input logic [WINDOW_LEN-1:0] w);
    logic [WINDOW_LEN-1:0] p;
    cur_sync = w;
    for (int n = 0; n < PATTERN_COUNT; n++) begin
      p = (n >= 4) ? swap_rails(w) : w;
      if ((n & 1) != 0) p = rotate_quadrant(p);
      if ((n & 2) != 0) p = ~p;
      pat_bank[n] = p;
    end
  endtask

  task automatic clear_frame_state();
    win_bits     = '0;
    sample_idx   = 0;
    frame_locked = 1'b0;
    for (int n = 0; n < PATTERN_COUNT; n++) begin
      top_score[n] = 0;
      top_start[n] = 0;
    end
  endtask

  // Model of one accepted sample beat; queues the result it causes, if any.
  task automatic correlate_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
    logic        hard;
    int unsigned slot;
    int unsigned start;
    int unsigned score;
    int unsigned peak;
    int          pick;
    result_t     r;
    hard = (smp <= HARD_ONE_MAX);
    slot = sample_idx;
    r    = '0;
    // after an early hit the rest of the frame is dropped, frame end only clears
    if (frame_locked) begin
      if (last) clear_frame_state();
      return;
    end
    fed_samples++;
    win_bits = {win_bits[WINDOW_LEN-2:0], hard};
    if (sample_idx < FRAME_MAX + WINDOW_LEN) sample_idx++;
    if (last) begin
      // end of frame: highest best score, lowest index on a tie; all zero if none
      peak = 0;
      pick = 0;
      for (int n = 0; n < PATTERN_COUNT; n++) begin
        if (top_score[n] > peak) begin
          peak = top_score[n];
          pick = n;
        end
      end
      if (peak > 0) begin
        r.found         = 1'b1;
        r.pattern_index = IDX_W'(pick);
        r.best_position = POS_W'(top_start[pick]);
        r.peak_score    = SCORE_W'(peak);
      end
      pending_results.push_back(r);
      results_due++;
      clear_frame_state();
      return;
    end
    // the window closing on this beat starts 63 samples back; none past the frame limit
    if (slot >= WINDOW_LEN - 1 && slot - (WINDOW_LEN - 1) < FRAME_MAX) begin
      start = slot - (WINDOW_LEN - 1);
      for (int n = 0; n < PATTERN_COUNT; n++) begin
        score = $countones(~(win_bits ^ pat_bank[n]));
        if (score > top_score[n]) begin
          top_score[n] = score;
          top_start[n] = start;
          if (score > cur_limit) begin
            r.found         = 1'b1;
            r.pattern_index = IDX_W'(n);
            r.best_position = POS_W'(start);
            r.peak_score    = SCORE_W'(score);
            r.early_hit     = 1'b1;
            pending_results.push_back(r);
            results_due++;
            frame_locked = 1'b1;
            return;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking: every output beat against the oldest owed result
  // ---------------------------------------------------------------------------------------
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: stray result, expected none, actual %0b/%0d/%0d/%0d/%0b",
                 $time, found_o, pattern_index_o, best_position_o, peak_score_o,
                 early_hit_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("found", want.found, found_o);
        compare_field("pattern_index", want.pattern_index, pattern_index_o);
        compare_field("best_position", want.best_position, best_position_o);
        compare_field("peak_score", want.peak_score, peak_score_o);
        compare_field("early_hit", want.early_hit, early_hit_o);
      end
    end
  end

  // Receiver back-pressure: random stall bursts, changed on the falling edge
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------------------

  // Soft byte for a wanted hard decision; leans on the threshold neighbours and the rails
  function automatic logic [SAMPLE_W-1:0] soft_byte(input logic hard);
    logic [SAMPLE_W-1:0] b;
    case ($urandom_range(0, 7))
      0:       b = hard ? HARD_ONE_MAX : HARD_ONE_MAX + 8'd1;
      1:       b = hard ? 8'd0 : 8'd255;
      default: b = hard ? SAMPLE_W'($urandom_range(0, 127))
                        : SAMPLE_W'($urandom_range(128, 255));
    endcase
    return b;
  endfunction

  // One sample beat, with an optional idle burst ahead of it; valid stays high between
  // back-to-back beats.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    soft_sample_i <= smp;
    frame_end_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    correlate_sample(smp, last);
    @(negedge clk_i);
  endtask

  task automatic send_noise(input int count, input bit end_frame);
    for (int i = 0; i < count; i++) begin
      send_sample(SAMPLE_W'($urandom_range(0, 255)), end_frame && i == count - 1);
    end
  endtask

  // 64-bit word as hard decisions, oldest (MSB) first, with some bits flipped
  task automatic send_word(input logic [WINDOW_LEN-1:0] w, input int flips,
                           input bit end_frame);
    logic [WINDOW_LEN-1:0] v;
    int                    pos;
    v = w;
    repeat (flips) begin
      pos    = $urandom_range(0, WINDOW_LEN - 1);
      v[pos] = ~v[pos];
    end
    for (int i = WINDOW_LEN - 1; i >= 0; i--) begin
      send_sample(soft_byte(v[i]), end_frame && i == 0);
    end
  endtask

  // noise, word, noise; frame end on the last beat (on the word itself when post is 0)
  task automatic send_frame(input int pre, input logic [WINDOW_LEN-1:0] w, input int flips,
                            input int post);
    send_noise(pre, 1'b0);
    send_word(w, flips, post == 0);
    send_noise(post, 1'b1);
  endtask

  // Block idle: no sample beat offered, every owed result out, pipeline given time to empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Leaves cfg valid high so that writes can go back to back; set_regs lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WINDOW_LEN-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SYNC_WORD) begin
      load_sync_word(data);
    end else if (idx == CFG_DETECT_LIMIT) begin
      cur_limit = data[SCORE_W-1:0];
    end
    @(negedge clk_i);
  endtask

  // Limit goes in the low bits; the rest of the data word is random and must be ignored
  task automatic set_regs(input logic [WINDOW_LEN-1:0] sync, input logic [SCORE_W-1:0] limit,
                          input bit spare);
    logic [WINDOW_LEN-1:0] ldata;
    ldata = {$urandom, $urandom};
    ldata[SCORE_W-1:0] = limit;
    settle_block();
    write_reg(CFG_SYNC_WORD, sync);
    write_reg(CFG_DETECT_LIMIT, ldata);
    if (spare) write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WINDOW_LEN-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset values: all-zero word, limit 55. A 64-beat frame closes its only window on the
  // last beat, which is never scored, so nothing is found. One beat more scores window 0.
  task automatic test_window_edge();
    logic [SAMPLE_W-1:0] edge_vals [4];
    edge_vals = '{8'd0, 8'd127, 8'd128, 8'd255};
    for (int i = 0; i < WINDOW_LEN; i++) begin
      send_sample(edge_vals[i % 4], i == WINDOW_LEN - 1);
    end
    for (int i = 0; i <= WINDOW_LEN; i++) begin
      send_sample(edge_vals[(i + 1) % 4], i == WINDOW_LEN);
    end
  endtask

  // All-zero window against the reset word scores 64 > 55: early hit at window 0, the
  // tail of the frame (frame end included) gives nothing, and the next frame starts clean.
  task automatic test_early_hit();
    for (int i = 0; i < WINDOW_LEN + 6; i++) send_sample(8'd255, i == WINDOW_LEN + 5);
    send_noise(3, 1'b1);
  endtask

  // Each of the eight derived patterns found on its own with early hits off. The other
  // words give duplicate patterns, so one frame each checks that a tie goes to the lowest
  // index.
  task automatic test_pattern_bank();
    logic [WINDOW_LEN-1:0] words [5];
    words = '{random_word(), '0, '1, WORD_EVEN, WORD_ODD};
    foreach (words[w]) begin
      set_regs(words[w], 7'd64, 1'b0);
      for (int n = 0; n < PATTERN_COUNT; n++) begin
        if (w == 0 || n == 2 * w - 1) send_frame($urandom_range(0, 6), pat_bank[n], 0, 3);
      end
    end
  endtask

  // Limit extremes, spare register indexes, and the limit's upper data bits ignored
  task automatic test_limit_extremes();
    set_regs(random_word(), 7'd0, 1'b0);
    send_noise(80, 1'b1);
    set_regs(cur_sync, 7'd127, 1'b1);
    send_frame(10, pat_bank[3], 0, 10);
    set_regs(cur_sync, 7'd63, 1'b0);
    send_frame(4, pat_bank[6], 0, 4);
    settle_block();
    write_reg(CFG_SYNC_WORD, cur_sync);
    write_reg(CFG_DETECT_LIMIT, WINDOW_LEN'(64));
    write_reg(CFG_SPARE_LO, {$urandom, $urandom});
    write_reg(CFG_SPARE_HI, '0);
    cfg_valid_i <= 1'b0;
    send_frame(2, pat_bank[7], 0, 2);
    set_regs(cur_sync, DETECT_LIMIT_RST, 1'b0);
    send_frame(5, pat_bank[1], 2, 5);
  endtask

  // Sync word rewritten part way into a frame: patterns change at once, the frame's
  // window, count and best scores carry on.
  task automatic test_mid_frame_write();
    set_regs(random_word(), 7'd64, 1'b0);
    send_noise(40, 1'b0);
    settle_block();
    write_reg(CFG_SYNC_WORD, random_word());
    cfg_valid_i <= 1'b0;
    send_word(pat_bank[2], 1, 1'b0);
    send_noise(5, 1'b1);
  endtask

  task automatic random_config();
    logic [WINDOW_LEN-1:0] sync;
    logic [SCORE_W-1:0]    limit;
    case ($urandom_range(0, 6))
      0:       sync = '0;
      1:       sync = '1;
      2:       sync = WORD_EVEN;
      3:       sync = WORD_ODD;
      default: sync = random_word();
    endcase
    case ($urandom_range(0, 7))
      0:       limit = 7'd0;
      1:       limit = 7'd64;
      2:       limit = 7'd127;
      3:       limit = DETECT_LIMIT_RST;
      default: limit = SCORE_W'($urandom_range(44, 62));
    endcase
    set_regs(sync, limit, $urandom_range(0, 5) == 0);
  endtask

  // Mostly well-formed frames (noisy copies of a derived pattern), some with two
  // candidates, plus pure noise, short frames and words ending right on the frame end.
  task automatic random_frame();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        send_frame($urandom_range(0, 24), pat_bank[$urandom_range(0, 7)],
                   $urandom_range(0, 10), $urandom_range(0, 24));
      end
      6: begin
        send_noise($urandom_range(0, 10), 1'b0);
        send_word(pat_bank[$urandom_range(0, 7)], $urandom_range(0, 12), 1'b0);
        send_frame($urandom_range(0, 20), pat_bank[$urandom_range(0, 7)],
                   $urandom_range(0, 12), $urandom_range(0, 8));
      end
      7:       send_noise($urandom_range(1, 120), 1'b1);
      8:       send_noise($urandom_range(1, WINDOW_LEN), 1'b1);
      default: send_frame($urandom_range(0, 8), pat_bank[$urandom_range(0, 7)],
                          $urandom_range(0, 20), $urandom_range(0, 1));
    endcase
  endtask

  task automatic test_random_frames();
    int unsigned fed0;
    int          frames;
    fed0   = fed_samples;
    frames = 0;
    while (fed_samples - fed0 < RANDOM_ITEMS) begin
      if (frames % 6 == 0) begin
        random_config();
        idle_en = ($urandom_range(0, 4) != 0);   // some phases run flat out
      end
      random_frame();
      frames++;
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_quiet_tail();
    idle_en = 1'b0;
    random_config();
    repeat (2) random_frame();
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    cur_limit = DETECT_LIMIT_RST;
    load_sync_word('0);
    clear_frame_state();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_window_edge();
    test_early_hit();
    test_pattern_bank();
    test_limit_extremes();
    test_mid_frame_write();
    test_random_frames();
    test_quiet_tail();

    settle_block();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/qswc_pkg.sv
sv/qswc_front.sv
sv/qswc_queue.sv
sv/qswc_back.sv
sv/qpsk_sync_word_correlator.sv
sv/qswc_checker.sv
dv/tb_top.sv
